@@ hdl/sliding_window_min_max_sum_core_defines.svh @@
// Assertion macros shared by the sliding window min/max/sum RTL.
// No dependencies; included by the files that carry assertions.
`ifndef SLIDING_WINDOW_MIN_MAX_SUM_CORE_DEFINES_SVH
`define SLIDING_WINDOW_MIN_MAX_SUM_CORE_DEFINES_SVH

// same-cycle implication, disabled in reset
`define SWMMS_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled in reset
`define SWMMS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ hdl/swmms_pkg.sv @@
// Package for the sliding window min/max/sum core: sizes, register map, stage control.
// No dependencies.
package swmms_pkg;

    localparam int WINDOW_MAX_DEF  = 64;
    localparam int SAMPLE_BITS_DEF = 16;
    localparam int SUM_BITS        = 48;
    localparam int CFG_W           = 7;
    localparam int PADDR_W         = 3;
    localparam int PDATA_W         = 32;
    localparam int REG_IDX_W       = PADDR_W - 2;

    localparam logic [REG_IDX_W-1:0] REG_WINDOW_SIZE = REG_IDX_W'(0);
    localparam logic [CFG_W-1:0]     WINDOW_SIZE_RST = CFG_W'(1);

    typedef struct packed {
        logic valid;
        logic win_ready;
        logic last;
    } t_stage_ctl;

endpackage

@@ hdl/swmms_chan_if.sv @@
// Stream channel interfaces: sample requests in, window results out.
// Depends on swmms_pkg for default widths.
interface swmms_in_if #(
    parameter int SAMPLE_BITS = swmms_pkg::SAMPLE_BITS_DEF
);
    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] sample;
    logic                          last;

    modport source (output valid, output sample, output last, input ready);
    modport sink   (input valid, input sample, input last, output ready);
endinterface

interface swmms_out_if #(
    parameter int SAMPLE_BITS = swmms_pkg::SAMPLE_BITS_DEF
);
    logic                                 valid;
    logic                                 ready;
    logic signed [SAMPLE_BITS-1:0]        window_min;
    logic signed [SAMPLE_BITS-1:0]        window_max;
    logic                                 window_ready;
    logic signed [swmms_pkg::SUM_BITS-1:0] running_sum;
    logic                                 sequence_done;

    modport source (output valid, output window_min, output window_max,
                    output window_ready, output running_sum, output sequence_done,
                    input ready);
    modport sink   (input valid, input window_min, input window_max,
                    input window_ready, input running_sum, input sequence_done,
                    output ready);
endinterface

@@ hdl/sliding_window_min_max_sum_core.sv @@
// Sliding window min/max core with a saturating 48-bit sum of min plus max per window.
// One sample request is taken per clock and held back only while the result register
// is full and not taken; each result is registered in the cells and stage r_a, then in the
// result register. The rate is set by the cell chain, where each cell compares the sample
// with its neighbor's min and max, and by the saturating add. No clearing pass after reset.
`include "sliding_window_min_max_sum_core_defines.svh"
module sliding_window_min_max_sum_core #(
    parameter int WINDOW_MAX  = swmms_pkg::WINDOW_MAX_DEF,
    parameter int SAMPLE_BITS = swmms_pkg::SAMPLE_BITS_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    swmms_in_if.sink                           i_in,
    swmms_out_if.source                        o_out,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [swmms_pkg::PADDR_W-1:0]      paddr,
    input  logic [swmms_pkg::PDATA_W-1:0]      pwdata,
    output logic [swmms_pkg::PDATA_W-1:0]      prdata,
    output logic                               pready
);
    import swmms_pkg::*;

    localparam int SIZE_W = $clog2(WINDOW_MAX + 1);
    localparam int IDX_W  = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
    localparam int EW     = (SIZE_W > CFG_W) ? SIZE_W : CFG_W;

    logic [CFG_W-1:0]              r_window_size;
    logic [EW-1:0]                 w_ws_ext, w_eff_ext;
    logic [SIZE_W-1:0]             w_eff, w_eff_m1;
    logic [IDX_W-1:0]              w_sel;
    logic [SIZE_W-1:0]             r_fill, n_fill;
    logic                          w_accept, w_advance, w_cfg_wr;
    logic [REG_IDX_W-1:0]          w_reg_idx;
    t_stage_ctl                    r_a;
    logic signed [SAMPLE_BITS-1:0] w_cmin [WINDOW_MAX];
    logic signed [SAMPLE_BITS-1:0] w_cmax [WINDOW_MAX];

    // config port
    assign w_reg_idx = paddr[PADDR_W-1:2];
    assign w_cfg_wr  = psel && penable && pwrite && pready;
    assign pready    = 1'b1;
    assign prdata    = (w_reg_idx == REG_WINDOW_SIZE) ? PDATA_W'(r_window_size) : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_window_size <= WINDOW_SIZE_RST;
        end else if (w_cfg_wr && w_reg_idx == REG_WINDOW_SIZE) begin
            r_window_size <= pwdata[CFG_W-1:0];
        end
    end

    // effective window size, clamped to 1..WINDOW_MAX
    always_comb begin
        w_ws_ext = EW'(r_window_size);
        if (w_ws_ext == '0) begin
            w_eff_ext = EW'(1);
        end else if (w_ws_ext > EW'(WINDOW_MAX)) begin
            w_eff_ext = EW'(WINDOW_MAX);
        end else begin
            w_eff_ext = w_ws_ext;
        end
        w_eff    = w_eff_ext[SIZE_W-1:0];
        w_eff_m1 = w_eff - SIZE_W'(1);
        w_sel    = w_eff_m1[IDX_W-1:0];
    end

    assign i_in.ready = w_advance;
    assign w_accept   = i_in.valid && w_advance;
    assign n_fill     = (r_fill < w_eff) ? r_fill + SIZE_W'(1) : w_eff;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill <= '0;
            r_a    <= '0;
        end else begin
            if (w_accept) begin
                r_fill <= i_in.last ? '0 : n_fill;
            end
            if (w_advance) begin
                r_a.valid     <= i_in.valid;
                r_a.win_ready <= (n_fill == w_eff);
                r_a.last      <= i_in.last;
            end
        end
    end

    // cell chain: cell k holds min/max of the newest k+1 samples
    for (genvar k = 0; k < WINDOW_MAX; k++) begin : g_cell
        logic signed [SAMPLE_BITS-1:0] w_nb_min, w_nb_max;
        if (k == 0) begin : g_head
            assign w_nb_min = i_in.sample;
            assign w_nb_max = i_in.sample;
        end else begin : g_body
            assign w_nb_min = w_cmin[k-1];
            assign w_nb_max = w_cmax[k-1];
        end
        swmms_cell #(
            .SAMPLE_BITS (SAMPLE_BITS)
        ) u_cell (
            .i_clk    (i_clk),
            .i_en     (w_accept),
            .i_sample (i_in.sample),
            .i_nb_min (w_nb_min),
            .i_nb_max (w_nb_max),
            .o_min    (w_cmin[k]),
            .o_max    (w_cmax[k])
        );
    end

    swmms_acc #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_acc (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_ctl     (r_a),
        .i_min     (w_cmin[w_sel]),
        .i_max     (w_cmax[w_sel]),
        .o_advance (w_advance),
        .o_out     (o_out)
    );

    `SWMMS_ASSERT_NEXT(a_fill_clear, i_clk, i_rst_n, w_accept && i_in.last, r_fill == '0, "fill count not cleared after last")
    `SWMMS_ASSERT_NEXT(a_stage_hold, i_clk, i_rst_n, r_a.valid && !w_advance, r_a.valid, "stalled request dropped")
endmodule

@@ hdl/swmms_cell.sv @@
// One cell of the suffix min/max chain: holds min and max of the newest k+1 samples.
// Depends on swmms_pkg for the default sample width.
module swmms_cell #(
    parameter int SAMPLE_BITS = swmms_pkg::SAMPLE_BITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_en,
    input  logic signed [SAMPLE_BITS-1:0] i_sample,
    input  logic signed [SAMPLE_BITS-1:0] i_nb_min,
    input  logic signed [SAMPLE_BITS-1:0] i_nb_max,
    output logic signed [SAMPLE_BITS-1:0] o_min,
    output logic signed [SAMPLE_BITS-1:0] o_max
);
    logic signed [SAMPLE_BITS-1:0] r_min, r_max;
    logic signed [SAMPLE_BITS-1:0] n_min, n_max;

    always_comb begin
        n_min = (i_sample < i_nb_min) ? i_sample : i_nb_min;
        n_max = (i_sample > i_nb_max) ? i_sample : i_nb_max;
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_min <= n_min;
            r_max <= n_max;
        end
    end

    assign o_min = r_min;
    assign o_max = r_max;
endmodule

@@ hdl/swmms_acc.sv @@
// Saturating accumulate stage and result register of the window core.
// Depends on swmms_pkg, swmms_chan_if and the assertion macro header.
`include "sliding_window_min_max_sum_core_defines.svh"
module swmms_acc #(
    parameter int SAMPLE_BITS = swmms_pkg::SAMPLE_BITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  swmms_pkg::t_stage_ctl         i_ctl,
    input  logic signed [SAMPLE_BITS-1:0] i_min,
    input  logic signed [SAMPLE_BITS-1:0] i_max,
    output logic                          o_advance,
    swmms_out_if.source                   o_out
);
    import swmms_pkg::*;

    localparam int EXT_W = SUM_BITS + 1;

    logic signed [SUM_BITS-1:0]    r_sum, n_sum;
    logic signed [EXT_W-1:0]       w_total;
    logic signed [SAMPLE_BITS-1:0] w_min, w_max;
    logic                          w_take;

    logic                          r_o_valid;
    logic signed [SAMPLE_BITS-1:0] r_o_min, r_o_max;
    logic                          r_o_win_ready;
    logic signed [SUM_BITS-1:0]    r_o_sum;
    logic                          r_o_done;

    assign o_advance = !r_o_valid || o_out.ready;
    assign w_take    = o_advance && i_ctl.valid;

    always_comb begin
        w_min   = i_ctl.win_ready ? i_min : '0;
        w_max   = i_ctl.win_ready ? i_max : '0;
        w_total = EXT_W'(r_sum) + EXT_W'(w_min) + EXT_W'(w_max);
        n_sum   = r_sum;
        if (i_ctl.win_ready) begin
            if (w_total[EXT_W-1] != w_total[EXT_W-2]) begin
                n_sum = w_total[EXT_W-1] ? {1'b1, {(SUM_BITS-1){1'b0}}}
                                         : {1'b0, {(SUM_BITS-1){1'b1}}};
            end else begin
                n_sum = w_total[SUM_BITS-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum     <= '0;
            r_o_valid <= 1'b0;
        end else begin
            if (o_advance) begin
                r_o_valid <= i_ctl.valid;
            end
            if (w_take) begin
                r_sum <= i_ctl.last ? '0 : n_sum;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_o_min       <= w_min;
            r_o_max       <= w_max;
            r_o_win_ready <= i_ctl.win_ready;
            r_o_sum       <= n_sum;
            r_o_done      <= i_ctl.last;
        end
    end

    assign o_out.valid         = r_o_valid;
    assign o_out.window_min    = r_o_min;
    assign o_out.window_max    = r_o_max;
    assign o_out.window_ready  = r_o_win_ready;
    assign o_out.running_sum   = r_o_sum;
    assign o_out.sequence_done = r_o_done;

    `SWMMS_ASSERT_NEXT(a_sum_cleared, i_clk, i_rst_n, w_take && i_ctl.last, r_sum == '0, "sum not cleared after last")
    `SWMMS_ASSERT_SAME(a_partial_zero, i_clk, i_rst_n, r_o_valid && !r_o_win_ready, r_o_min == '0 && r_o_max == '0, "min/max nonzero on partial window")
endmodule

@@ test/tb_sliding_window_min_max_sum_core.sv @@
// Testbench for sliding_window_min_max_sum_core: random and directed sample streams,
// window results checked against an in-bench predictor, window size set over APB.
// Depends on swmms_pkg, swmms_in_if/swmms_out_if and the core RTL.
module tb_sliding_window_min_max_sum_core;
    timeunit 1ns;
    timeprecision 1ps;
    import swmms_pkg::*;

    localparam int WMAX        = WINDOW_MAX_DEF;
    localparam int SBITS       = SAMPLE_BITS_DEF;
    localparam int STALL_LIMIT = 2000;
    localparam longint SUM_HI  = (longint'(1) << (SUM_BITS - 1)) - 1;
    localparam longint SUM_LO  = -(longint'(1) << (SUM_BITS - 1));

    typedef struct {
        logic signed [SBITS-1:0] sample;
        logic                    last;
    } t_sample_req;

    typedef struct {
        logic signed [SBITS-1:0]    wmin;
        logic signed [SBITS-1:0]    wmax;
        logic                       wready;
        logic signed [SUM_BITS-1:0] sum;
        logic                       done;
    } t_window_res;

    logic               i_clk   = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               psel    = 1'b0;
    logic               penable = 1'b0;
    logic               pwrite  = 1'b0;
    logic [PADDR_W-1:0] paddr   = '0;
    logic [PDATA_W-1:0] pwdata  = '0;
    logic [PDATA_W-1:0] prdata;
    logic               pready;

    swmms_in_if  #(.SAMPLE_BITS(SBITS)) in_if ();
    swmms_out_if #(.SAMPLE_BITS(SBITS)) out_if ();

    sliding_window_min_max_sum_core #(
        .WINDOW_MAX (WMAX),
        .SAMPLE_BITS(SBITS)
    ) dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_in   (in_if),
        .o_out  (out_if),
        .psel   (psel),
        .penable(penable),
        .pwrite (pwrite),
        .paddr  (paddr),
        .pwdata (pwdata),
        .prdata (prdata),
        .pready (pready)
    );

    always #4 i_clk = ~i_clk;

    t_sample_req req_queue[$];
    t_window_res expected_windows[$];

    logic signed [SBITS-1:0]    win_hist[WMAX];
    int                         fill_level  = 0;
    logic signed [SUM_BITS-1:0] min_max_sum = '0;
    logic [CFG_W-1:0]           size_mirror = WINDOW_SIZE_RST;

    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int err_count      = 0;
    int quiet_cycles   = 0;

    function automatic int clamp_size(logic [CFG_W-1:0] sz);
        if (sz == 0)
            return 1;
        if (sz > WMAX)
            return WMAX;
        return int'(sz);
    endfunction

    function automatic t_window_res predict_window(logic signed [SBITS-1:0] smp, logic last_in);
        t_window_res             r;
        int                      eff;
        longint                  t;
        logic signed [SBITS-1:0] mn;
        logic signed [SBITS-1:0] mx;
        eff = clamp_size(size_mirror);
        for (int i = WMAX - 1; i > 0; i--)
            win_hist[i] = win_hist[i-1];
        win_hist[0] = smp;
        if (fill_level < eff)
            fill_level++;
        if (fill_level > eff)
            fill_level = eff;
        mn = '0;
        mx = '0;
        r.wready = 1'b0;
        if (fill_level == eff) begin
            r.wready = 1'b1;
            mn = win_hist[0];
            mx = win_hist[0];
            for (int i = 1; i < eff; i++) begin
                if (win_hist[i] < mn)
                    mn = win_hist[i];
                if (win_hist[i] > mx)
                    mx = win_hist[i];
            end
            t = longint'(min_max_sum) + longint'(mn) + longint'(mx);
            if (t > SUM_HI)
                t = SUM_HI;
            if (t < SUM_LO)
                t = SUM_LO;
            min_max_sum = SUM_BITS'(t);
        end
        r.wmin = mn;
        r.wmax = mx;
        r.sum  = min_max_sum;
        r.done = last_in;
        if (last_in) begin
            for (int i = 0; i < WMAX; i++)
                win_hist[i] = '0;
            fill_level  = 0;
            min_max_sum = '0;
        end
        return r;
    endfunction

    task automatic report_mismatch(string what, longint got, longint want);
        $display("[%0t] MISMATCH %s: got %0d, expected %0d", $realtime, what, got, want);
        err_count++;
    endtask

    // driver: one request at a time, prediction taken at acceptance
    always @(posedge i_clk) begin
        t_sample_req nxt;
        if (!i_rst_n) begin
            in_if.valid  <= 1'b0;
            in_if.sample <= '0;
            in_if.last   <= 1'b0;
        end else begin
            if (in_if.valid && in_if.ready)
                expected_windows.push_back(predict_window(in_if.sample, in_if.last));
            if (!in_if.valid || in_if.ready) begin
                if (req_queue.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
                    nxt = req_queue.pop_front();
                    in_if.valid  <= 1'b1;
                    in_if.sample <= nxt.sample;
                    in_if.last   <= nxt.last;
                end else begin
                    in_if.valid <= 1'b0;
                end
            end
        end
    end

    // monitor
    always @(posedge i_clk) begin
        t_window_res want;
        if (!i_rst_n) begin
            out_if.ready <= 1'b0;
        end else begin
            if (out_if.valid && out_if.ready) begin
                if (expected_windows.size() == 0) begin
                    report_mismatch("result with no request pending", 0, 0);
                end else begin
                    want = expected_windows.pop_front();
                    if (out_if.window_min !== want.wmin)
                        report_mismatch("window_min", out_if.window_min, want.wmin);
                    if (out_if.window_max !== want.wmax)
                        report_mismatch("window_max", out_if.window_max, want.wmax);
                    if (out_if.window_ready !== want.wready)
                        report_mismatch("window_ready", out_if.window_ready, want.wready);
                    if (out_if.running_sum !== want.sum)
                        report_mismatch("running_sum", out_if.running_sum, want.sum);
                    if (out_if.sequence_done !== want.done)
                        report_mismatch("sequence_done", out_if.sequence_done, want.done);
                end
            end
            out_if.ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
                quiet_cycles <= 0;
            end else if (quiet_cycles >= STALL_LIMIT) begin
                $display("Test completed with failures");
                $finish;
            end else begin
                quiet_cycles <= quiet_cycles + 1;
            end
        end
    end

    task automatic push_req(logic signed [SBITS-1:0] s, logic l);
        t_sample_req r;
        r.sample = s;
        r.last   = l;
        req_queue.push_back(r);
    endtask

    task automatic drain_requests();
        do
            @(negedge i_clk);
        while (req_queue.size() != 0 || in_if.valid || expected_windows.size() != 0);
        repeat (4) @(negedge i_clk);
    endtask

    task automatic write_window_size(logic [CFG_W-1:0] val);
        drain_requests();
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= PADDR_W'({REG_WINDOW_SIZE, 2'b00});
        pwdata  <= PDATA_W'(val);
        @(posedge i_clk);
        penable <= 1'b1;
        do
            @(posedge i_clk);
        while (!pready);
        size_mirror = val;
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    function automatic logic signed [SBITS-1:0] rand_sample();
        int pick;
        pick = $urandom_range(99);
        if (pick < 70)
            return SBITS'($urandom);
        if (pick < 80) begin
            case ($urandom_range(3))
                0: return 16'sh7fff;
                1: return 16'sh8000;
                2: return 16'sh0000;
                default: return 16'shffff;
            endcase
        end
        return SBITS'($urandom_range(16) - 8);
    endfunction

    initial begin
        int eff;
        int len;
        int items;
        int choice;
        logic [CFG_W-1:0] sz;

        in_if.valid  = 1'b0;
        in_if.sample = '0;
        in_if.last   = 1'b0;
        out_if.ready = 1'b0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // window size 1 out of reset: every sample is its own window
        push_req(16'sh7fff, 1'b0);
        push_req(16'sh8000, 1'b0);
        push_req(16'sh0000, 1'b0);
        push_req(16'shffff, 1'b0);
        push_req(16'sh0001, 1'b1);

        write_window_size(CFG_W'(3));
        push_req(16'sh8000, 1'b0);
        push_req(16'sh7fff, 1'b0);
        push_req(16'sh0000, 1'b0);
        push_req(16'sh0005, 1'b1);
        // too short for the window: total stays zero
        push_req(16'sh0001, 1'b0);
        push_req(16'sh0002, 1'b1);

        // zero is taken as one; sequence left open across the next write
        write_window_size(CFG_W'(0));
        push_req(16'sh0007, 1'b0);
        push_req(16'shfff9, 1'b0);

        // above the maximum clamps to WMAX, window grows mid-sequence
        write_window_size(CFG_W'(127));
        for (int k = 0; k < 10; k++)
            push_req(rand_sample(), k == 9);

        for (int ph = 0; ph < 8; ph++) begin
            drain_requests();
            case (ph % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 54; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 54; end
                default: begin send_idle_pct = 16; recv_stall_pct = 16; end
            endcase
            case (ph)
                0: sz = CFG_W'(1);
                1: sz = CFG_W'(64);
                2: sz = CFG_W'(127);
                3: sz = CFG_W'(2);
                4: sz = CFG_W'(0);
                5: sz = CFG_W'($urandom_range(3, 16));
                6: sz = CFG_W'($urandom_range(0, 127));
                default: sz = CFG_W'($urandom_range(1, 64));
            endcase
            write_window_size(sz);
            eff = clamp_size(sz);
            items = 0;
            while (items < 165) begin
                choice = $urandom_range(99);
                if (choice < 75) begin
                    len = eff + $urandom_range(0, 2 * eff + 8);
                    for (int k = 0; k < len; k++)
                        push_req(rand_sample(), k == len - 1);
                end else if (choice < 90) begin
                    len = $urandom_range(1, eff);
                    for (int k = 0; k < len; k++)
                        push_req(rand_sample(), k == len - 1);
                end else begin
                    len = $urandom_range(1, 20);
                    for (int k = 0; k < len; k++)
                        push_req(rand_sample(), $urandom_range(3) == 0);
                end
                items += len;
                // hold the sender until everything is back, once mid-phase
                if (ph == 5 && items >= 100 && items - len < 100)
                    drain_requests();
            end
            // at random, leave a sequence open so the next size change lands mid-sequence
            if ($urandom_range(1) == 1) begin
                len = $urandom_range(1, 2 * eff);
                for (int k = 0; k < len; k++)
                    push_req(rand_sample(), 1'b0);
            end
        end

        drain_requests();
        repeat (8) @(posedge i_clk);
        if (err_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
